@@ rtl/pda_pkg.sv @@
// types and constants for the pid controller with deadband and anti-windup
// no dependencies; used by pid_deadband_antiwindup
package pda_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_INT_MUL,
    S_INT_ADD,
    S_DEC_LO,
    S_DEC_HI,
    S_DEC_SUM,
    S_DEC_FIN,
    S_GI_LO,
    S_GI_HI,
    S_GI_SUM,
    S_GI_TEST,
    S_DIV_CLAMP,
    S_CLAMP_FIX,
    S_DER_START,
    S_DIV_DER,
    S_DER_FIX,
    S_SUM_P,
    S_SUM_GLO,
    S_SUM_GHI,
    S_SUM_D,
    S_SUM_ACC,
    S_ABS,
    S_ROUND,
    S_LIMIT,
    S_OUT
  } state_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_NORMAL    = 3'd0,
    ST_ZERO_DT   = 3'd1,
    ST_DEADBAND  = 3'd2,
    ST_SATURATED = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEADBAND       = 3'd0,
    REG_OUTPUT_LIMIT   = 3'd1,
    REG_INTEGRAL_LIMIT = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_GAIN_D         = 3'd5
  } reg_e;

  localparam logic signed [16:0] DecayQ16   = 17'sd58982;
  localparam logic [22:0]        DerivMax   = 23'h7FFFFF;
  localparam logic [22:0]        OutLimRst  = 23'd4096;
  localparam logic [22:0]        IntLimRst  = 23'd8192;
  localparam logic [15:0]        GainPRst   = 16'd179;
  localparam logic [5:0]         DivSteps   = 6'd47;

endpackage

@@ rtl/pid_deadband_antiwindup.sv @@
// pid controller with deadband and integrator anti-windup
// one shared 17x25 multiplier and one radix-2 divider under a sequencer
// depends on pda_pkg
//
// usage:
//  - input channel in_valid_i / in_stall_o carries req_type, error_in and
//    time_step; a transaction is taken when valid is high and stall is low
//  - output channel out_valid_o / out_stall_i carries drive and status,
//    exactly one result per input transaction
//  - config channel cfg_valid_i / cfg_ready_o writes register cfg_index_i
//    with cfg_data_i; ready is always high, write only while idle
//  - one item at a time: in_stall_o is high from acceptance until the
//    result is loaded into the output register
//  - paths: clear and zero time step go straight to the output state,
//    deadband decays the integrator, a full compute divides for the
//    derivative and adds the integral limit test when it runs and the
//    integrator clamp division when it fires; each division runs 48 steps
//  - the next item is taken in the cycle after the result loads
//  - the output register holds its result while out_stall_i is high; the
//    next item may be taken meanwhile and waits in the last state
//  - reset (rst_ni low, asynchronous) zeroes integrator and previous error
//    and loads the register reset values
module pid_deadband_antiwindup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [23:0] error_in_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] drive_o,
  output logic [2:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i
);

  pda_pkg::state_e state_q, state_d;

  // configuration
  logic [22:0]        deadband_q, out_lim_q, int_lim_q;
  logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;

  // controller state
  logic signed [47:0] integ_q;
  logic signed [23:0] last_q;

  // latched request and working registers
  logic               req_q;
  logic signed [23:0] err_q;
  logic [15:0]        dt_q;
  logic signed [41:0] prod_q;
  logic signed [65:0] acc_q;
  logic [41:0]        rnd_q;
  logic               neg_q;
  logic signed [23:0] deriv_q;
  logic [47:0]        dq_q;
  logic [15:0]        dv_q;
  logic [16:0]        rem_q;
  logic [5:0]         cnt_q;
  logic signed [23:0] res_drive_q;
  logic [2:0]         res_status_q;

  // output register
  logic               out_valid_q;
  logic signed [23:0] drive_q;
  logic [2:0]         status_q;

  // shared multiplier operands
  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;

  logic               in_acc, cfg_wr, out_load;
  logic signed [24:0] err_x, diff_x;
  logic [24:0]        err_mag, diff_mag;
  logic [47:0]        integ_mag;
  logic signed [48:0] int_sum;
  logic signed [47:0] int_sat;
  logic signed [65:0] prod_x, lim_x;
  logic               gt_lim, lt_lim;
  logic [16:0]        div_t;
  logic               div_ge;
  logic [47:0]        dec_m;
  logic [22:0]        der_s;
  logic [22:0]        drv_mag;
  logic               drv_sat;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load   = (state_q == pda_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign status_o    = status_q;

  // shared arithmetic helpers
  assign err_x     = {err_q[23], err_q};
  assign err_mag   = err_x[24] ? 25'(-err_x) : 25'(err_x);
  assign diff_x    = err_x - {last_q[23], last_q};
  assign diff_mag  = diff_x[24] ? 25'(-diff_x) : 25'(diff_x);
  assign integ_mag = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);
  assign prod_x    = 66'(prod_q);
  assign int_sum   = 49'(integ_q) + 49'(prod_q);
  assign lim_x     = $signed({19'd0, int_lim_q, 24'd0});
  assign gt_lim    = acc_q > lim_x;
  assign lt_lim    = acc_q < -lim_x;
  assign div_t     = {rem_q[15:0], dq_q[47]};
  assign div_ge    = div_t >= {1'b0, dv_q};
  assign dec_m     = acc_q[63:16];
  assign der_s     = (|dq_q[47:23]) ? pda_pkg::DerivMax : dq_q[22:0];
  assign drv_sat   = rnd_q > {19'd0, out_lim_q};
  assign drv_mag   = drv_sat ? out_lim_q : rnd_q[22:0];

  // 48-bit saturation of the integrator update
  always_comb begin
    if (int_sum[48] != int_sum[47]) begin
      int_sat = int_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      int_sat = int_sum[47:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pda_pkg::S_IDLE:      if (in_acc) state_d = pda_pkg::S_CHECK;
      pda_pkg::S_CHECK: begin
        if (req_q || dt_q == 16'd0) begin
          state_d = pda_pkg::S_OUT;
        end else if (err_mag < {2'd0, deadband_q}) begin
          state_d = pda_pkg::S_DEC_LO;
        end else begin
          state_d = pda_pkg::S_INT_MUL;
        end
      end
      pda_pkg::S_INT_MUL:   state_d = pda_pkg::S_INT_ADD;
      pda_pkg::S_INT_ADD: begin
        if (int_lim_q != 23'd0 && gain_i_q != 16'sd0) state_d = pda_pkg::S_GI_LO;
        else state_d = pda_pkg::S_DER_START;
      end
      pda_pkg::S_DEC_LO:    state_d = pda_pkg::S_DEC_HI;
      pda_pkg::S_DEC_HI:    state_d = pda_pkg::S_DEC_SUM;
      pda_pkg::S_DEC_SUM:   state_d = pda_pkg::S_DEC_FIN;
      pda_pkg::S_DEC_FIN:   state_d = pda_pkg::S_OUT;
      pda_pkg::S_GI_LO:     state_d = pda_pkg::S_GI_HI;
      pda_pkg::S_GI_HI:     state_d = pda_pkg::S_GI_SUM;
      pda_pkg::S_GI_SUM:    state_d = pda_pkg::S_GI_TEST;
      pda_pkg::S_GI_TEST: begin
        if (gt_lim || lt_lim) state_d = pda_pkg::S_DIV_CLAMP;
        else state_d = pda_pkg::S_DER_START;
      end
      pda_pkg::S_DIV_CLAMP: if (cnt_q == 6'd0) state_d = pda_pkg::S_CLAMP_FIX;
      pda_pkg::S_CLAMP_FIX: state_d = pda_pkg::S_DER_START;
      pda_pkg::S_DER_START: state_d = pda_pkg::S_DIV_DER;
      pda_pkg::S_DIV_DER:   if (cnt_q == 6'd0) state_d = pda_pkg::S_DER_FIX;
      pda_pkg::S_DER_FIX:   state_d = pda_pkg::S_SUM_P;
      pda_pkg::S_SUM_P:     state_d = pda_pkg::S_SUM_GLO;
      pda_pkg::S_SUM_GLO:   state_d = pda_pkg::S_SUM_GHI;
      pda_pkg::S_SUM_GHI:   state_d = pda_pkg::S_SUM_D;
      pda_pkg::S_SUM_D:     state_d = pda_pkg::S_SUM_ACC;
      pda_pkg::S_SUM_ACC:   state_d = pda_pkg::S_ABS;
      pda_pkg::S_ABS:       state_d = pda_pkg::S_ROUND;
      pda_pkg::S_ROUND:     state_d = pda_pkg::S_LIMIT;
      pda_pkg::S_LIMIT:     state_d = pda_pkg::S_OUT;
      pda_pkg::S_OUT:       if (out_load) state_d = pda_pkg::S_IDLE;
      default:              state_d = pda_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: stall and multiplier operand select
  always_comb begin
    in_stall_o = (state_q != pda_pkg::S_IDLE);
    mul_a = 17'sd0;
    mul_b = 25'sd0;
    unique case (state_q)
      pda_pkg::S_INT_MUL: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = err_x;
      end
      pda_pkg::S_DEC_LO: begin
        mul_a = pda_pkg::DecayQ16;
        mul_b = $signed({1'b0, integ_mag[23:0]});
      end
      pda_pkg::S_DEC_HI: begin
        mul_a = pda_pkg::DecayQ16;
        mul_b = $signed({1'b0, integ_mag[47:24]});
      end
      pda_pkg::S_GI_LO, pda_pkg::S_SUM_GLO: begin
        mul_a = 17'(gain_i_q);
        mul_b = $signed({1'b0, integ_q[23:0]});
      end
      pda_pkg::S_GI_HI, pda_pkg::S_SUM_GHI: begin
        mul_a = 17'(gain_i_q);
        mul_b = 25'($signed(integ_q[47:24]));
      end
      pda_pkg::S_SUM_P: begin
        mul_a = 17'(gain_p_q);
        mul_b = err_x;
      end
      pda_pkg::S_SUM_D: begin
        mul_a = 17'(gain_d_q);
        mul_b = 25'(deriv_q);
      end
      default: begin
        mul_a = 17'sd0;
        mul_b = 25'sd0;
      end
    endcase
  end

  // control, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pda_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      deadband_q  <= 23'd0;
      out_lim_q   <= pda_pkg::OutLimRst;
      int_lim_q   <= pda_pkg::IntLimRst;
      gain_p_q    <= pda_pkg::GainPRst;
      gain_i_q    <= 16'sd0;
      gain_d_q    <= 16'sd0;
      integ_q     <= 48'sd0;
      last_q      <= 24'sd0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index_i)
          pda_pkg::REG_DEADBAND:       deadband_q <= cfg_data_i;
          pda_pkg::REG_OUTPUT_LIMIT:   out_lim_q  <= cfg_data_i;
          pda_pkg::REG_INTEGRAL_LIMIT: int_lim_q  <= cfg_data_i;
          pda_pkg::REG_GAIN_P:         gain_p_q   <= cfg_data_i[15:0];
          pda_pkg::REG_GAIN_I:         gain_i_q   <= cfg_data_i[15:0];
          pda_pkg::REG_GAIN_D:         gain_d_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        pda_pkg::S_CHECK: begin
          if (req_q) begin
            integ_q <= 48'sd0;
            last_q  <= 24'sd0;
          end
        end
        pda_pkg::S_INT_ADD:   integ_q <= int_sat;
        pda_pkg::S_DEC_FIN: begin
          integ_q <= integ_q[47] ? 48'(-dec_m) : 48'(dec_m);
          last_q  <= err_q;
        end
        pda_pkg::S_CLAMP_FIX: integ_q <= neg_q ? 48'(-dq_q) : 48'(dq_q);
        pda_pkg::S_DER_FIX:   last_q  <= err_q;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      req_q <= req_type_i;
      err_q <= error_in_i;
      dt_q  <= time_step_i;
    end
    unique case (state_q)
      pda_pkg::S_CHECK: begin
        res_drive_q <= 24'sd0;
        if (req_q) res_status_q <= pda_pkg::ST_CLEARED;
        else if (dt_q == 16'd0) res_status_q <= pda_pkg::ST_ZERO_DT;
        else res_status_q <= pda_pkg::ST_DEADBAND;
      end
      pda_pkg::S_DEC_HI, pda_pkg::S_GI_HI: acc_q <= prod_x;
      pda_pkg::S_DEC_SUM, pda_pkg::S_GI_SUM, pda_pkg::S_SUM_D:
        acc_q <= acc_q + (prod_x <<< 24);
      pda_pkg::S_GI_TEST: begin
        // clamp to limit over gain, division on magnitudes
        neg_q <= gt_lim ? gain_i_q[15] : !gain_i_q[15];
        dq_q  <= {1'b0, int_lim_q, 24'd0};
        dv_q  <= gain_i_q[15] ? 16'(-gain_i_q) : 16'(gain_i_q);
        rem_q <= 17'd0;
        cnt_q <= pda_pkg::DivSteps;
      end
      pda_pkg::S_DIV_CLAMP, pda_pkg::S_DIV_DER: begin
        rem_q <= div_ge ? 17'(div_t - {1'b0, dv_q}) : div_t;
        dq_q  <= {dq_q[46:0], div_ge};
        cnt_q <= cnt_q - 6'd1;
      end
      pda_pkg::S_DER_START: begin
        neg_q <= diff_x[24];
        dq_q  <= {7'd0, diff_mag, 16'd0};
        dv_q  <= dt_q;
        rem_q <= 17'd0;
        cnt_q <= pda_pkg::DivSteps;
      end
      pda_pkg::S_DER_FIX:
        deriv_q <= neg_q ? 24'(-{1'b0, der_s}) : 24'({1'b0, der_s});
      pda_pkg::S_SUM_GLO:   acc_q <= prod_x <<< 16;
      pda_pkg::S_SUM_GHI:   acc_q <= acc_q + prod_x;
      pda_pkg::S_SUM_ACC:   acc_q <= acc_q + (prod_x <<< 16);
      pda_pkg::S_ABS: begin
        neg_q <= acc_q[65];
        acc_q <= acc_q[65] ? -acc_q : acc_q;
      end
      pda_pkg::S_ROUND: rnd_q <= 42'((acc_q + 66'sd8388608) >>> 24);
      pda_pkg::S_LIMIT: begin
        res_drive_q  <= neg_q ? 24'(-{1'b0, drv_mag}) : 24'({1'b0, drv_mag});
        res_status_q <= drv_sat ? pda_pkg::ST_SATURATED : pda_pkg::ST_NORMAL;
      end
      default: ;
    endcase
    if (out_load) begin
      drive_q  <= res_drive_q;
      status_q <= res_status_q;
    end
  end

endmodule
